// ===== rtl/pfa_pkg.sv =====
// Shared types and constants for the page frame allocator.
// Used by pfa_div, pfa_table and page_frame_allocator_top.
package pfa_pkg;

  localparam int NUM_FRAMES_DEF      = 64;
  localparam int RESERVED_FRAMES_DEF = 5;

  localparam int SIZE_W  = 10;
  localparam int PS_W    = 4;
  localparam int PID_W   = 8;
  localparam int IDX_W   = 6;
  localparam int CNT_W   = 7;
  // quotient plus the round-up bit, with one bit of headroom
  localparam int PAGES_W = 11;

  localparam logic [PS_W-1:0] PAGE_SIZE_RESET = 4'd5;

  typedef enum logic [1:0] {
    KIND_FREE   = 2'd0,
    KIND_SYSTEM = 2'd1,
    KIND_OWNED  = 2'd2
  } kind_t;

  typedef enum logic [1:0] {
    CMD_ALLOC   = 2'd0,
    CMD_RELEASE = 2'd1,
    CMD_READ    = 2'd2,
    CMD_NONE    = 2'd3
  } cmd_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SCAN,
    ST_READ,
    ST_OUT
  } state_t;

  typedef struct packed {
    kind_t             kind;
    logic [PID_W-1:0]  owner;
    logic [PS_W-1:0]   fill;
  } entry_t;

  typedef struct packed {
    logic              done;
    logic [SIZE_W-1:0] quot;
    logic [PS_W-1:0]   rem;
  } div_res_t;

endpackage

// ===== rtl/pfa_div.sv =====
// Restoring divider, one quotient bit per cycle: size units by page size.
// Depends on pfa_pkg.
module pfa_div import pfa_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  input  logic [SIZE_W-1:0] dividend,
  input  logic [PS_W-1:0]   divisor,
  output div_res_t          res
);

  localparam int STEP_W = $clog2(SIZE_W + 1);

  logic              busy;
  logic              done;
  logic [STEP_W-1:0] steps;
  logic [SIZE_W-1:0] quot;
  logic [PS_W-1:0]   rem;
  logic [PS_W-1:0]   dsr;
  logic [PS_W:0]     trial;
  logic              ge;

  always_comb begin
    trial = {rem, quot[SIZE_W-1]};
    ge    = (trial >= {1'b0, dsr});
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      steps <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy  <= 1'b1;
        steps <= STEP_W'(SIZE_W);
      end else if (busy) begin
        steps <= steps - 1'b1;
        if (steps == STEP_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      quot <= dividend;
      rem  <= '0;
      dsr  <= divisor;
    end else if (busy) begin
      quot <= {quot[SIZE_W-2:0], ge};
      // partial remainder stays below the divisor, so 4 bits hold it
      rem  <= ge ? PS_W'(trial - {1'b0, dsr}) : trial[PS_W-1:0];
    end
  end

  assign res.done = done;
  assign res.quot = quot;
  assign res.rem  = rem;

endmodule

// ===== rtl/pfa_table.sv =====
// Frame table memory: one write and one registered read port per cycle.
// Per-entry written bits make unwritten entries read as their reset value.
// Depends on pfa_pkg.
module pfa_table import pfa_pkg::*; #(
  parameter  int NUM_FRAMES      = NUM_FRAMES_DEF,
  parameter  int RESERVED_FRAMES = RESERVED_FRAMES_DEF,
  localparam int AW              = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1
) (
  input  logic          clk,
  input  logic          rst,
  input  logic [AW-1:0] raddr,
  output entry_t        rdata,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  entry_t        wdata
);

  localparam int FIRST_SYS = (RESERVED_FRAMES >= NUM_FRAMES) ? 0
                             : NUM_FRAMES - RESERVED_FRAMES;

  entry_t                  mem [NUM_FRAMES];
  logic [NUM_FRAMES-1:0]   written;
  entry_t                  rd_mem;
  logic                    rd_written;
  logic                    rd_sys;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_mem <= mem[raddr];
    rd_sys <= (32'(raddr) >= FIRST_SYS);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      written    <= '0;
      rd_written <= 1'b0;
    end else begin
      if (we) begin
        written[waddr] <= 1'b1;
      end
      rd_written <= written[raddr];
    end
  end

  always_comb begin
    if (rd_written) begin
      rdata = rd_mem;
    end else if (rd_sys) begin
      rdata = '{kind: KIND_SYSTEM, owner: '0, fill: PAGE_SIZE_RESET};
    end else begin
      rdata = '{kind: KIND_FREE, owner: '0, fill: '0};
    end
  end

endmodule

// ===== rtl/page_frame_allocator_top.sv =====
// Page frame allocator: first-fit frame table, one item at a time.
// Allocate runs the 10-step divider, then one table pass; a refused allocate skips the pass.
// Release makes one table pass, read does one table read, and cmd 3 goes straight to output.
// The next item is accepted only once the previous result has loaded; a stalled
// result holds the block in its output state. Synchronous reset clears the frame
// table at once and sets page size to 5.
module page_frame_allocator_top import pfa_pkg::*; #(
  parameter int NUM_FRAMES      = NUM_FRAMES_DEF,
  parameter int RESERVED_FRAMES = RESERVED_FRAMES_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              cfg_we,
  input  logic [PS_W-1:0]   cfg_wdata,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        cmd,
  input  logic [PID_W-1:0]  process_id,
  input  logic [SIZE_W-1:0] size_units,
  input  logic [IDX_W-1:0]  frame_index,
  output logic              out_valid,
  input  logic              out_stall,
  output logic              granted,
  output logic [CNT_W-1:0]  free_count,
  output logic [CNT_W-1:0]  frames_touched,
  output logic [1:0]        entry_kind,
  output logic [PID_W-1:0]  entry_owner,
  output logic [PS_W-1:0]   entry_fill
);

  localparam int AW        = (NUM_FRAMES > 1) ? $clog2(NUM_FRAMES) : 1;
  localparam int FW        = $clog2(NUM_FRAMES + 1);
  localparam int FIRST_SYS = (RESERVED_FRAMES >= NUM_FRAMES) ? 0
                             : NUM_FRAMES - RESERVED_FRAMES;

  state_t             state;
  state_t             state_next;
  logic [PS_W-1:0]    page_size;
  logic [PS_W-1:0]    ps_eff;
  cmd_t               op;
  cmd_t               cmd_in;
  logic [PID_W-1:0]   pid;
  logic [FW-1:0]      scan_idx;
  logic               pend;
  logic [AW-1:0]      pend_addr;
  logic [FW-1:0]      done_cnt;
  logic [PAGES_W-1:0] pages;
  logic [PAGES_W-1:0] pages_calc;
  logic [PS_W-1:0]    rem_r;
  logic [FW-1:0]      free_frames;
  logic               rd_oor;
  logic               res_granted;
  logic [FW-1:0]      res_touched;
  kind_t              res_kind;
  logic [PID_W-1:0]   res_owner;
  logic [PS_W-1:0]    res_fill;

  logic               accept;
  logic               div_start;
  logic               fit;
  logic               issue;
  logic               scan_end;
  logic               hit;
  logic               last_page;
  logic               out_free;
  div_res_t           div_res;
  logic [AW-1:0]      raddr;
  entry_t             rd;
  entry_t             wdata;

  pfa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (size_units),
    .divisor  (ps_eff),
    .res      (div_res)
  );

  pfa_table #(
    .NUM_FRAMES      (NUM_FRAMES),
    .RESERVED_FRAMES (RESERVED_FRAMES)
  ) u_table (
    .clk   (clk),
    .rst   (rst),
    .raddr (raddr),
    .rdata (rd),
    .we    (hit),
    .waddr (pend_addr),
    .wdata (wdata)
  );

  assign in_stall = rst || (state != ST_IDLE);
  assign accept   = in_valid && !in_stall;
  assign cmd_in   = cmd_t'(cmd);
  assign ps_eff   = (page_size == '0) ? PS_W'(1) : page_size;
  assign out_free = !out_valid || !out_stall;
  assign raddr    = (state == ST_SCAN) ? scan_idx[AW-1:0] : AW'(frame_index);

  always_comb begin
    pages_calc = PAGES_W'(div_res.quot) + PAGES_W'(div_res.rem != '0);
    fit        = (pages_calc <= PAGES_W'(free_frames));
    issue      = (state == ST_SCAN) && (32'(scan_idx) < NUM_FRAMES);
    scan_end   = (state == ST_SCAN) && !issue && !pend;
    last_page  = (PAGES_W'(done_cnt) + PAGES_W'(1) == pages) && (rem_r != '0);
    if (op == CMD_ALLOC) begin
      hit   = pend && (rd.kind == KIND_FREE) && (PAGES_W'(done_cnt) < pages);
      wdata = '{kind: KIND_OWNED, owner: pid, fill: last_page ? rem_r : ps_eff};
    end else begin
      hit   = pend && (rd.kind == KIND_OWNED) && (rd.owner == pid);
      wdata = '{kind: KIND_FREE, owner: '0, fill: '0};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    div_start  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          unique case (cmd_in)
            CMD_ALLOC: begin
              state_next = ST_DIV;
              div_start  = 1'b1;
            end
            CMD_RELEASE: state_next = ST_SCAN;
            CMD_READ:    state_next = ST_READ;
            default:     state_next = ST_OUT;
          endcase
        end
      end
      ST_DIV: begin
        if (div_res.done) begin
          state_next = fit ? ST_SCAN : ST_OUT;
        end
      end
      ST_SCAN: begin
        if (scan_end) begin
          state_next = ST_OUT;
        end
      end
      ST_READ: state_next = ST_OUT;
      ST_OUT: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      page_size   <= PAGE_SIZE_RESET;
      free_frames <= FW'(FIRST_SYS);
      pend        <= 1'b0;
    end else begin
      if (cfg_we) begin
        page_size <= cfg_wdata;
      end
      pend <= issue;
      if (scan_end) begin
        if (op == CMD_ALLOC) begin
          free_frames <= free_frames - done_cnt;
        end else begin
          free_frames <= free_frames + done_cnt;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op          <= cmd_in;
      pid         <= process_id;
      scan_idx    <= '0;
      done_cnt    <= '0;
      rd_oor      <= !(32'(frame_index) < NUM_FRAMES);
      res_granted <= 1'b0;
      res_touched <= '0;
      res_kind    <= KIND_FREE;
      res_owner   <= '0;
      res_fill    <= '0;
    end
    if (state == ST_DIV && div_res.done) begin
      pages <= pages_calc;
      rem_r <= div_res.rem;
    end
    if (issue) begin
      scan_idx  <= scan_idx + 1'b1;
      pend_addr <= scan_idx[AW-1:0];
    end
    if (hit) begin
      done_cnt <= done_cnt + 1'b1;
    end
    if (scan_end) begin
      res_touched <= done_cnt;
      res_granted <= (op == CMD_ALLOC);
    end
    // out-of-table reads report a free frame
    if (state == ST_READ && !rd_oor) begin
      res_kind  <= rd.kind;
      res_owner <= (rd.kind == KIND_OWNED) ? rd.owner : '0;
      res_fill  <= rd.fill;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (state == ST_OUT && out_free) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_OUT && out_free) begin
      granted        <= res_granted;
      free_count     <= CNT_W'(free_frames);
      frames_touched <= CNT_W'(res_touched);
      entry_kind     <= res_kind;
      entry_owner    <= res_owner;
      entry_fill     <= res_fill;
    end
  end

`ifndef NO_ASSERTIONS
  a_free_bound: assert property (@(posedge clk) disable iff (rst)
    32'(free_frames) <= FIRST_SYS)
    else $error("free frame count above the non-system frame count");

  a_alloc_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN && op == CMD_ALLOC) |-> (PAGES_W'(done_cnt) <= pages))
    else $error("allocate assigned more frames than pages requested");

  a_out_load: assert property (@(posedge clk) disable iff (rst)
    (state == ST_OUT && out_free) |=> (out_valid && state == ST_IDLE))
    else $error("finished item not moved to the output register");

  a_read_fields: assert property (@(posedge clk) disable iff (rst)
    (out_valid && entry_kind != KIND_FREE) |-> (!granted && frames_touched == '0))
    else $error("read result carries allocate or release fields");
`endif

endmodule

// ===== tb/tb_page_frame_allocator_top.sv =====
// Self-checking testbench for page_frame_allocator_top: allocate, release and read
// items are checked against a first-fit frame table model kept in the bench.
// Depends on pfa_pkg and page_frame_allocator_top.
`timescale 1ns / 1ps

module tb_page_frame_allocator_top;
  import pfa_pkg::*;

  localparam int WATCHDOG_LIMIT = 20000;
  localparam int DRAIN_CYCLES   = NUM_FRAMES_DEF + 40;
  localparam int CFG_SETTLE     = 4;

  typedef struct {
    cmd_t              op;
    logic [PID_W-1:0]  pid;
    logic [SIZE_W-1:0] units;
    logic [IDX_W-1:0]  idx;
  } frame_req_t;

  typedef struct packed {
    logic             granted;
    logic [CNT_W-1:0] free_count;
    logic [CNT_W-1:0] touched;
    logic [1:0]       kind;
    logic [PID_W-1:0] owner;
    logic [PS_W-1:0]  fill;
  } frame_rsp_t;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              cfg_we = 1'b0;
  logic [PS_W-1:0]   cfg_wdata = '0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [1:0]        cmd = '0;
  logic [PID_W-1:0]  process_id = '0;
  logic [SIZE_W-1:0] size_units = '0;
  logic [IDX_W-1:0]  frame_index = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic              granted;
  logic [CNT_W-1:0]  free_count;
  logic [CNT_W-1:0]  frames_touched;
  logic [1:0]        entry_kind;
  logic [PID_W-1:0]  entry_owner;
  logic [PS_W-1:0]   entry_fill;

  page_frame_allocator_top uut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
    .in_valid(in_valid), .in_stall(in_stall), .cmd(cmd), .process_id(process_id),
    .size_units(size_units), .frame_index(frame_index),
    .out_valid(out_valid), .out_stall(out_stall), .granted(granted),
    .free_count(free_count), .frames_touched(frames_touched),
    .entry_kind(entry_kind), .entry_owner(entry_owner), .entry_fill(entry_fill)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Frame table copy and page size as the bench sees them
  kind_t            tbl_kind  [NUM_FRAMES_DEF];
  logic [PID_W-1:0] tbl_owner [NUM_FRAMES_DEF];
  logic [PS_W-1:0]  tbl_fill  [NUM_FRAMES_DEF];
  int               tbl_free;
  logic [PS_W-1:0]  page_size_q = PAGE_SIZE_RESET;

  frame_req_t pending_reqs[$];
  frame_rsp_t expected_rsps[$];
  frame_req_t cur_req;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int gap_left = 0;
  int idle_cycles = 0;
  int n_errors = 0;
  int n_checked = 0;
  int n_alloc = 0;
  int n_granted = 0;
  int n_release = 0;
  int n_read = 0;
  int n_sizes = 1;

  function automatic void reset_frame_table();
    for (int i = 0; i < NUM_FRAMES_DEF; i++) begin
      tbl_kind[i]  = (i >= NUM_FRAMES_DEF - RESERVED_FRAMES_DEF) ? KIND_SYSTEM : KIND_FREE;
      tbl_owner[i] = '0;
      tbl_fill[i]  = (tbl_kind[i] == KIND_SYSTEM) ? PAGE_SIZE_RESET : '0;
    end
    tbl_free = NUM_FRAMES_DEF - RESERVED_FRAMES_DEF;
  endfunction

  function automatic frame_rsp_t predict_frame_op(frame_req_t rq);
    frame_rsp_t rs;
    int unit;
    int rem;
    int pages;
    int done;
    rs = '0;
    case (rq.op)
      CMD_ALLOC: begin
        n_alloc++;
        unit  = (page_size_q == 0) ? 1 : int'(page_size_q);
        rem   = int'(rq.units) % unit;
        pages = int'(rq.units) / unit + ((rem != 0) ? 1 : 0);
        if (pages <= tbl_free) begin
          done = 0;
          for (int i = 0; i < NUM_FRAMES_DEF && done < pages; i++) begin
            if (tbl_kind[i] == KIND_FREE) begin
              tbl_kind[i]  = KIND_OWNED;
              tbl_owner[i] = rq.pid;
              // last frame keeps the remainder, others a full page
              tbl_fill[i]  = (done + 1 == pages && rem != 0) ? PS_W'(rem) : PS_W'(unit);
              done++;
            end
          end
          tbl_free  -= done;
          rs.granted = 1'b1;
          rs.touched = CNT_W'(done);
          n_granted++;
        end
      end
      CMD_RELEASE: begin
        n_release++;
        done = 0;
        for (int i = 0; i < NUM_FRAMES_DEF; i++) begin
          if (tbl_kind[i] == KIND_OWNED && tbl_owner[i] == rq.pid) begin
            tbl_kind[i]  = KIND_FREE;
            tbl_owner[i] = '0;
            tbl_fill[i]  = '0;
            done++;
          end
        end
        tbl_free  += done;
        rs.touched = CNT_W'(done);
      end
      CMD_READ: begin
        n_read++;
        rs.kind  = tbl_kind[rq.idx];
        rs.owner = (tbl_kind[rq.idx] == KIND_OWNED) ? tbl_owner[rq.idx] : '0;
        rs.fill  = tbl_fill[rq.idx];
      end
      default: ;
    endcase
    rs.free_count = CNT_W'(tbl_free);
    return rs;
  endfunction

  function automatic void check_field(string name, int exp_val, int act_val);
    if (exp_val != act_val) begin
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_val, act_val);
      n_errors++;
    end
  endfunction

  // Driver: present one item at a time, hold it while stalled
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        expected_rsps.insert(expected_rsps.size(), predict_frame_op(cur_req));
      end
      if (!in_valid || !in_stall) begin
        if (gap_left > 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          cur_req = pending_reqs.pop_front();
          cmd         <= cur_req.op;
          process_id  <= cur_req.pid;
          size_units  <= cur_req.units;
          frame_index <= cur_req.idx;
          in_valid    <= 1'b1;
        end else begin
          in_valid <= 1'b0;
          // now and then open a long gap so the block runs dry
          if (send_idle_pct != 0 && $urandom_range(99) < 3) gap_left = $urandom_range(100, 1);
        end
      end
    end
  end

  // Monitor: compare each result with the oldest expectation
  always @(posedge clk) begin
    frame_rsp_t exp_rsp;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_rsps.size() == 0) begin
          $display("%0t: result with no item outstanding", $time);
          n_errors++;
        end else begin
          exp_rsp = expected_rsps.pop_front();
          check_field("granted", exp_rsp.granted, granted);
          check_field("free_count", exp_rsp.free_count, free_count);
          check_field("frames_touched", exp_rsp.touched, frames_touched);
          check_field("entry_kind", exp_rsp.kind, entry_kind);
          check_field("entry_owner", exp_rsp.owner, entry_owner);
          check_field("entry_fill", exp_rsp.fill, entry_fill);
          n_checked++;
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: no handshake for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  task automatic push_req(cmd_t op, int pid, int units, int idx);
    frame_req_t rq;
    rq.op    = op;
    rq.pid   = PID_W'(pid);
    rq.units = SIZE_W'(units);
    rq.idx   = IDX_W'(idx);
    pending_reqs.insert(pending_reqs.size(), rq);
  endtask

  task automatic wait_drained();
    do @(negedge clk);
    while (pending_reqs.size() != 0 || in_valid || expected_rsps.size() != 0);
  endtask

  task automatic write_page_size(logic [PS_W-1:0] ps);
    wait_drained();
    repeat (CFG_SETTLE) @(negedge clk);
    @(posedge clk);
    cfg_we      <= 1'b1;
    cfg_wdata   <= ps;
    page_size_q  = ps;
    @(posedge clk);
    cfg_we <= 1'b0;
    n_sizes++;
  endtask

  function automatic frame_req_t make_random_req(int unit, logic [PID_W-1:0] id_base);
    frame_req_t rq;
    int r;
    int pages;
    int sz;
    rq.op    = cmd_t'($urandom_range(3));
    rq.pid   = PID_W'($urandom);
    rq.units = SIZE_W'($urandom);
    rq.idx   = IDX_W'($urandom);
    r = $urandom_range(99);
    // small id pool so releases find owned frames
    if ($urandom_range(9) < 8) rq.pid = id_base + PID_W'($urandom_range(7));
    if (r < 45) begin
      rq.op = CMD_ALLOC;
      r = $urandom_range(99);
      if (r < 50)      pages = $urandom_range(4);
      else if (r < 75) pages = $urandom_range(20, 5);
      else if (r < 90) pages = $urandom_range(60, 20);
      else             pages = -1;
      if (pages < 0)       sz = $urandom_range(1023);
      else if (pages == 0) sz = 0;
      else                 sz = pages * unit - $urandom_range(unit - 1);
      if (sz > 1023) sz = 1023;
      rq.units = SIZE_W'(sz);
    end else if (r < 73) begin
      rq.op = CMD_RELEASE;
    end else if (r < 97) begin
      rq.op = CMD_READ;
      if ($urandom_range(9) < 6) rq.idx = IDX_W'($urandom_range(15));
    end else begin
      rq.op = CMD_NONE;
    end
    return rq;
  endfunction

  task automatic run_phase(logic [PS_W-1:0] ps, int s_idle, int r_idle, int count);
    logic [PID_W-1:0] id_base;
    int unit;
    write_page_size(ps);
    @(negedge clk);
    send_idle_pct = s_idle;
    recv_idle_pct = r_idle;
    id_base = PID_W'($urandom_range(255));
    unit = (ps == 0) ? 1 : int'(ps);
    for (int i = 0; i < count; i++) begin
      // hold off mid-phase until every result is back
      if (i == count / 2) wait_drained();
      pending_reqs.insert(pending_reqs.size(), make_random_req(unit, id_base));
    end
  endtask

  initial begin
    reset_frame_table();
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);

    // directed: table edges, exact fit, failures, holes, releases
    push_req(CMD_READ, 0, 0, 0);
    push_req(CMD_READ, 0, 0, NUM_FRAMES_DEF - RESERVED_FRAMES_DEF - 1);
    push_req(CMD_READ, 0, 0, NUM_FRAMES_DEF - RESERVED_FRAMES_DEF);
    push_req(CMD_READ, 255, 1023, 63);
    push_req(CMD_NONE, 255, 1023, 63);
    push_req(CMD_ALLOC, 0, 0, 0);
    push_req(CMD_ALLOC, 255, 1, 0);
    push_req(CMD_ALLOC, 1, 10, 0);
    push_req(CMD_ALLOC, 2, 12, 0);
    push_req(CMD_READ, 0, 0, 1);
    push_req(CMD_READ, 0, 0, 5);
    push_req(CMD_ALLOC, 3, 1023, 0);
    push_req(CMD_ALLOC, 4, 265, 0);
    push_req(CMD_ALLOC, 5, 1, 0);
    push_req(CMD_RELEASE, 1, 0, 0);
    push_req(CMD_RELEASE, 9, 0, 0);
    push_req(CMD_RELEASE, 0, 0, 0);
    push_req(CMD_ALLOC, 6, 7, 0);
    push_req(CMD_READ, 0, 0, 1);
    push_req(CMD_READ, 0, 0, 2);
    push_req(CMD_RELEASE, 4, 0, 0);
    push_req(CMD_RELEASE, 255, 0, 0);
    push_req(CMD_RELEASE, 2, 0, 0);
    push_req(CMD_RELEASE, 6, 0, 0);
    push_req(CMD_READ, 0, 0, 63);

    run_phase(4'd1,  0,  0,  250);
    run_phase(4'd15, 69, 0,  250);
    run_phase(4'd0,  0,  69, 250);
    run_phase(4'd7,  19, 19, 250);
    run_phase(4'd3,  0,  0,  250);
    run_phase(4'd10, 69, 0,  200);
    run_phase(4'd1,  0,  69, 200);
    run_phase(4'd15, 19, 19, 200);

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Checked %0d results across %0d page size settings and four idle modes.",
             n_checked, n_sizes);
    $display("Items: %0d allocates (%0d granted), %0d releases, %0d reads.",
             n_alloc, n_granted, n_release, n_read);
    if (n_errors == 0 && expected_rsps.size() == 0) begin
      $display("== PASS ==");
    end else begin
      if (expected_rsps.size() != 0)
        $display("%0t: %0d results never arrived", $time, expected_rsps.size());
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
